### sv/flc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flc_pkg
// Shared constants and types of the framed LED command receiver: frame
// marker bytes, status codes, store sizes and the parser result word.
// ----------------------------------------------------------------------------
package flc_pkg;

  // frame marker bytes
  localparam logic [7:0] SYNC1_BYTE = 8'hDE;
  localparam logic [7:0] SYNC2_BYTE = 8'hAD;
  localparam logic [7:0] STOP1_BYTE = 8'hBE;
  localparam logic [7:0] STOP2_BYTE = 8'hEF;

  // frame status codes
  localparam logic [2:0] ST_NONE    = 3'd0;
  localparam logic [2:0] ST_COMMIT  = 3'd1;
  localparam logic [2:0] ST_OTHER   = 3'd2;
  localparam logic [2:0] ST_BADSUM  = 3'd3;
  localparam logic [2:0] ST_BADSTOP = 3'd4;

  // input word kinds
  localparam logic CMD_RX   = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // store sizes and reset values
  localparam int         MSG_BYTES      = 256;
  localparam int         MSG_AW         = 8;
  localparam int         LED_BYTES_DEF  = 180;
  localparam logic [7:0] LED_EVEN_RESET = 8'd16;
  localparam logic [7:0] SET_LEDS_RESET = 8'd1;

  // parser result for one received byte
  typedef struct packed {
    logic              msg_we;
    logic [MSG_AW-1:0] msg_addr;
    logic [7:0]        msg_data;
    logic [2:0]        status;
    logic [7:0]        fcmd;
    logic              commit;
  } parse_res_t;

endpackage

### sv/framed_led_command_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_led_command_receiver
// Parses DE AD / length / command / data / XOR / BE EF frames from received
// bytes into a message RAM, copies it to the LED RAM on a set-LEDs frame and
// serves single-byte reads of the LED RAM.
// ----------------------------------------------------------------------------
// A receive word's result is registered in the output register, or in the
// skid stage while that is full. A read word's result comes from the
// registered LED RAM read data in the read state. A frame that commits starts
// a copy sweep, one entry a cycle from the message RAM's read port into the
// LED RAM's write port, during which no input word is taken. Data bytes land
// in the message RAM from address 0 upward, so a fill mark tells written
// entries from cleared ones, and a single flag tells whether a sweep has ever
// filled the LED RAM; words are taken from the first cycle after reset. The
// result path has an output register and a skid stage, so a new word is
// taken while one result waits to be collected.
module framed_led_command_receiver #(
  parameter int LED_BYTES = flc_pkg::LED_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_cmd,
  input  logic [7:0] in_rx_byte,
  input  logic [7:0] in_read_index,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_data,
  output logic [2:0] out_frame_status,
  output logic [7:0] out_frame_command,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  import flc_pkg::*;

  localparam int LED_AW = $clog2(LED_BYTES);
  localparam int LED_CW = $clog2(LED_BYTES + 1);
  localparam logic [LED_CW-1:0] LED_END = LED_CW'(LED_BYTES);
  localparam logic [8:0]        LED_LIM = 9'(LED_BYTES);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_COPY = 2'd2;

  // result word
  typedef struct packed {
    logic [7:0] rdata;
    logic [2:0] status;
    logic [7:0] fcmd;
  } result_t;

  logic [1:0]  state_r, state_nxt;
  logic [7:0]  set_code_r;
  logic        acc;
  parse_res_t  pres;

  logic [MSG_AW:0] msg_fill_r;
  logic            led_init_r;
  logic [7:0]      msg_q, led_q;

  logic [LED_CW-1:0] cnt_r;
  logic              copy_issue;
  logic              copy_v_r;
  logic              copy_mv_r;
  logic [LED_AW-1:0] copy_addr_r;

  logic              rd_inrange, rd_inrange_r, rd_vld_r, rd_even_r;

  logic    push, pop;
  result_t push_w;
  result_t out_r, skid_r;
  logic    out_v_r, skid_v_r;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_code_r <= SET_LEDS_RESET;
    end else if (cfg_wr_en) begin
      set_code_r <= cfg_wr_data;
    end
  end

  // input handshake
  assign in_ready = (state_r == S_IDLE) && !skid_v_r;
  assign acc      = in_valid && in_ready;

  flc_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (acc && (in_cmd == CMD_RX)),
    .rx_byte      (in_rx_byte),
    .set_leds_code(set_code_r),
    .res          (pres)
  );

  // message store
  flc_ram #(.WIDTH(8), .DEPTH(MSG_BYTES)) u_msg_ram (
    .clk  (clk),
    .we   (pres.msg_we),
    .waddr(pres.msg_addr),
    .wdata(pres.msg_data),
    .re   (copy_issue),
    .raddr(MSG_AW'(cnt_r)),
    .rdata(msg_q)
  );

  // led store
  flc_ram #(.WIDTH(8), .DEPTH(LED_BYTES)) u_led_ram (
    .clk  (clk),
    .we   (copy_v_r),
    .waddr(copy_addr_r),
    .wdata(copy_mv_r ? msg_q : 8'd0),
    .re   (acc && (in_cmd == CMD_READ)),
    .raddr(in_read_index[LED_AW-1:0]),
    .rdata(led_q)
  );

  // message fill mark and led written flag stand in for the reset contents
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msg_fill_r <= '0;
      led_init_r <= 1'b0;
    end else begin
      if (pres.msg_we && ({1'b0, pres.msg_addr} >= msg_fill_r)) begin
        msg_fill_r <= {1'b0, pres.msg_addr} + (MSG_AW + 1)'(1);
      end
      // a sweep writes every led entry before any word is taken again
      if (copy_v_r) led_init_r <= 1'b1;
    end
  end

  // read word capture
  assign rd_inrange = {1'b0, in_read_index} < LED_LIM;

  always_ff @(posedge clk) begin
    if (acc) begin
      rd_inrange_r <= rd_inrange;
      rd_vld_r     <= rd_inrange && led_init_r;
      rd_even_r    <= ~in_read_index[0];
    end
  end

  // commit copy sweep
  assign copy_issue = (state_r == S_COPY) && (cnt_r != LED_END);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      copy_v_r <= 1'b0;
    end else begin
      copy_v_r <= copy_issue;
      if (acc) cnt_r <= '0;
      else if (copy_issue) cnt_r <= cnt_r + LED_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (copy_issue) begin
      copy_addr_r <= cnt_r[LED_AW-1:0];
      copy_mv_r   <= ({1'b0, MSG_AW'(cnt_r)} < msg_fill_r);
    end
  end

  // control sequence
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (in_cmd == CMD_READ) state_nxt = S_READ;
          else if (pres.commit)   state_nxt = S_COPY;
        end
      end
      S_READ: state_nxt = S_IDLE;
      S_COPY: begin
        if ((cnt_r == LED_END) && copy_v_r) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // result formation
  assign push = (acc && (in_cmd == CMD_RX)) || (state_r == S_READ);

  always_comb begin
    if (state_r == S_READ) begin
      push_w.status = ST_NONE;
      push_w.fcmd   = 8'd0;
      if (!rd_inrange_r)  push_w.rdata = 8'd0;
      else if (rd_vld_r)  push_w.rdata = led_q;
      else if (rd_even_r) push_w.rdata = LED_EVEN_RESET;
      else                push_w.rdata = 8'd0;
    end else begin
      push_w.rdata  = 8'd0;
      push_w.status = pres.status;
      push_w.fcmd   = pres.fcmd;
    end
  end

  // output register with skid stage
  assign pop = out_v_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_v_r) begin
          out_v_r  <= 1'b1;
          skid_v_r <= push;
        end else begin
          out_v_r  <= push;
        end
      end else if (out_v_r) begin
        if (push) skid_v_r <= 1'b1;
      end else begin
        out_v_r <= push;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_v_r) begin
        out_r <= skid_r;
        if (push) skid_r <= push_w;
      end else if (push) begin
        out_r <= push_w;
      end
    end else if (out_v_r) begin
      if (push) skid_r <= push_w;
    end else if (push) begin
      out_r <= push_w;
    end
  end

  assign out_valid         = out_v_r;
  assign out_read_data     = out_r.rdata;
  assign out_frame_status  = out_r.status;
  assign out_frame_command = out_r.fcmd;

  // checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid stage full while output register empty");

  a_no_msg_write_in_copy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COPY) |-> !pres.msg_we)
    else $error("message store written during copy sweep");

  a_copy_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    copy_v_r |-> ({1'b0, copy_addr_r} < (LED_AW + 1)'(LED_BYTES)))
    else $error("copy write beyond led store");

  a_commit_starts_copy: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (in_cmd == CMD_RX) && pres.commit) |=> (state_r == S_COPY))
    else $error("committed frame did not start copy sweep");

  a_read_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (in_cmd == CMD_READ)) |=> (state_r == S_READ))
    else $error("read word did not enter read cycle");

endmodule

### sv/flc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module flc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/flc_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flc_parser
// Frame parser: hunts the sync pair, collects length, command and data,
// keeps the running checksum and judges checksum and stop bytes.
// ----------------------------------------------------------------------------
module flc_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  input  logic [7:0]          set_leds_code,
  output flc_pkg::parse_res_t res
);

  import flc_pkg::*;

  localparam logic [2:0] PH_SYNC1 = 3'd0;
  localparam logic [2:0] PH_SYNC2 = 3'd1;
  localparam logic [2:0] PH_LEN   = 3'd2;
  localparam logic [2:0] PH_CMD   = 3'd3;
  localparam logic [2:0] PH_DATA  = 3'd4;
  localparam logic [2:0] PH_CHK   = 3'd5;
  localparam logic [2:0] PH_STOP1 = 3'd6;
  localparam logic [2:0] PH_STOP2 = 3'd7;

  logic [2:0] phase_r, phase_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] fcmd_r, fcmd_nxt;
  logic [7:0] count_r, count_nxt;
  logic [7:0] xor_r, xor_nxt;

  // next parser state and result for this byte
  always_comb begin
    phase_nxt    = phase_r;
    len_nxt      = len_r;
    fcmd_nxt     = fcmd_r;
    count_nxt    = count_r;
    xor_nxt      = xor_r;
    res.msg_we   = 1'b0;
    res.msg_addr = count_r;
    res.msg_data = rx_byte;
    res.status   = ST_NONE;
    res.fcmd     = 8'd0;
    res.commit   = 1'b0;
    unique case (phase_r)
      PH_SYNC1: begin
        if (rx_byte == SYNC1_BYTE) phase_nxt = PH_SYNC2;
      end
      PH_SYNC2: begin
        if (rx_byte == SYNC2_BYTE) begin
          xor_nxt   = 8'd0;
          phase_nxt = PH_LEN;
        end else if (rx_byte != SYNC1_BYTE) begin
          phase_nxt = PH_SYNC1;
        end
      end
      PH_LEN: begin
        len_nxt   = rx_byte;
        xor_nxt   = xor_r ^ rx_byte;
        phase_nxt = PH_CMD;
      end
      PH_CMD: begin
        fcmd_nxt  = rx_byte;
        xor_nxt   = xor_r ^ rx_byte;
        count_nxt = 8'd0;
        phase_nxt = PH_DATA;
      end
      PH_DATA: begin
        xor_nxt    = xor_r ^ rx_byte;
        res.msg_we = step;
        count_nxt  = count_r + 8'd1;
        if (count_nxt >= len_r) phase_nxt = PH_CHK;
      end
      PH_CHK: begin
        if (rx_byte == xor_r) begin
          phase_nxt = PH_STOP1;
        end else begin
          res.status = ST_BADSUM;
          phase_nxt  = PH_SYNC1;
        end
      end
      PH_STOP1: begin
        if (rx_byte == STOP1_BYTE) begin
          phase_nxt = PH_STOP2;
        end else begin
          res.status = ST_BADSTOP;
          phase_nxt  = PH_SYNC1;
        end
      end
      PH_STOP2: begin
        if (rx_byte == STOP2_BYTE) begin
          res.fcmd = fcmd_r;
          if (fcmd_r == set_leds_code) begin
            res.status = ST_COMMIT;
            res.commit = 1'b1;
          end else begin
            res.status = ST_OTHER;
          end
        end else begin
          res.status = ST_BADSTOP;
        end
        phase_nxt = PH_SYNC1;
      end
    endcase
  end

  // parser registers advance on each accepted receive word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SYNC1;
      len_r   <= 8'd0;
      fcmd_r  <= 8'd0;
      count_r <= 8'd0;
      xor_r   <= 8'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      fcmd_r  <= fcmd_nxt;
      count_r <= count_nxt;
      xor_r   <= xor_nxt;
    end
  end

endmodule
